FILE: design/xtm_pkg.sv
// Package: widths, action and status codes, controller states for the xor trie unit.
`default_nettype none
package xtm_pkg;
    localparam int KEY_BITS   = 31;
    localparam int NODE_BITS  = 16;
    localparam int NODE_COUNT = 1 << NODE_BITS;
    localparam int CNT_BITS   = 20;
    localparam int LVL_BITS   = $clog2(KEY_BITS);
    localparam logic [CNT_BITS-1:0] COUNT_MAX = {CNT_BITS{1'b1}};

    typedef logic [NODE_BITS-1:0] t_node;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [KEY_BITS-1:0]  t_key;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_ERASE  = 2'd1,
        ACT_MAX    = 2'd2,
        ACT_MIN    = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // One node entry: both links and the pass count.
    typedef struct packed {
        t_node link0;
        t_node link1;
        t_cnt  cnt;
    } t_entry;

    localparam int ENTRY_BITS = 2 * NODE_BITS + CNT_BITS;

    typedef struct packed {
        logic   rd_en;
        t_node  rd_addr;
        logic   wr_en;
        t_node  wr_addr;
        t_entry wr_data;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RROOT,   // read root
        S_WROOT,   // wait root data
        S_PASS1,   // probe walk, one level per PASS1/P1WAIT pair
        S_P1WAIT,
        S_DECIDE,
        S_PASS2,   // update walk
        S_P2WAIT,
        S_QUERY,
        S_QWAIT,
        S_QCHILD,
        S_QCWAIT,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: design/xor_trie_multiset_unit.sv
// Top level: handshake, result register and node store of the xor trie multiset.
//
//  channel | dir | handshake           | fields
//  in      | in  | i_valid / o_ready   | i_action[1:0], i_key[30:0]
//  out     | out | o_valid / i_ready   | o_status[1:0], o_xor_value[30:0], o_partner[30:0]
//
// One item at a time over the node store's single read port. Insert or erase:
// probe walk, then update of root and 31 nodes (a refused item ends after the
// probe). Query: per level a node read and a child read; an empty set ends
// after the root read. The next item is accepted in the cycle after the
// result moves into the output register. Reset is
// synchronous; the root reads as empty until first written, so no clearing pass
// is needed. A finished result waits in the output register while the next item
// is already accepted; a walk that ends while that register is held stalls in
// its last state until it frees.
`default_nettype none
module xor_trie_multiset_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [30:0] i_key,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [1:0]       o_status,
    output logic [30:0]      o_xor_value,
    output logic [30:0]      o_partner
);
    xtm_pkg::t_mem_req w_req;
    xtm_pkg::t_entry   w_rd;
    xtm_pkg::t_status  w_st;
    xtm_pkg::t_key     w_xor, w_par;
    logic w_done, w_start, w_free, w_take;
    logic r_busy, r_valid;
    logic [1:0] r_status;
    logic [30:0] r_xor, r_par;

    // Accept when the walker is free.
    assign o_ready = !r_busy;
    assign w_start = i_valid && o_ready;
    // Output register takes a result when empty or emptying at this edge.
    assign w_free  = !r_valid || i_ready;
    assign w_take  = w_done && w_free;

    xtm_node_ram u_ram (.i_clk(i_clk), .i_req(w_req), .o_rd_data(w_rd));

    xtm_walker u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start), .i_free(w_free),
        .i_act(xtm_pkg::t_act'(i_action)), .i_key(i_key), .i_rd_data(w_rd),
        .o_req(w_req), .o_done(w_done), .o_status(w_st),
        .o_xor(w_xor), .o_partner(w_par)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            // Hold busy until the result moves into the output register.
            if (w_start) r_busy <= 1'b1;
            else if (w_take) r_busy <= 1'b0;
            if (w_take) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        if (w_take) begin
            r_status <= w_st;
            r_xor    <= w_xor;
            r_par    <= w_par;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_xor_value = r_xor;
    assign o_partner   = r_par;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> r_busy) else $error("start did not set busy");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> o_valid) else $error("result lost");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) &&
        $stable(o_xor_value) && $stable(o_partner)) else $error("result item changed");
endmodule
`default_nettype wire

FILE: design/xtm_node_ram.sv
// Node store: synchronous single-port-read, single-port-write memory.
`default_nettype none
module xtm_node_ram (
    input  wire logic               i_clk,
    input  wire xtm_pkg::t_mem_req  i_req,
    output xtm_pkg::t_entry         o_rd_data
);
    xtm_pkg::t_entry r_mem [xtm_pkg::NODE_COUNT];
    xtm_pkg::t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd;
endmodule
`default_nettype wire

FILE: design/xtm_walker.sv
// Walk sequencer: probes, updates and queries the trie one level at a time.
`default_nettype none
module xtm_walker (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_free,
    input  wire xtm_pkg::t_act     i_act,
    input  wire xtm_pkg::t_key     i_key,
    input  wire xtm_pkg::t_entry   i_rd_data,
    output xtm_pkg::t_mem_req      o_req,
    output logic                   o_done,
    output xtm_pkg::t_status       o_status,
    output xtm_pkg::t_key          o_xor,
    output xtm_pkg::t_key          o_partner
);
    typedef logic [xtm_pkg::LVL_BITS-1:0] t_lvl;
    typedef logic [xtm_pkg::NODE_BITS:0]  t_free;
    localparam t_lvl           TOP_LVL  = t_lvl'(xtm_pkg::KEY_BITS - 1);
    localparam t_free          FREE_RST = t_free'(2);
    localparam t_free          FREE_LIM = t_free'(xtm_pkg::NODE_COUNT);
    localparam xtm_pkg::t_node ROOT     = xtm_pkg::t_node'(1);

    xtm_pkg::t_state   r_state, n_state;
    xtm_pkg::t_act     r_act;
    xtm_pkg::t_key     r_key, r_y, n_y;
    t_lvl              r_lvl, n_lvl;
    xtm_pkg::t_node    r_u, n_u;
    xtm_pkg::t_node    r_qc, n_qc;        // preferred child during query
    xtm_pkg::t_node    r_qalt, n_qalt;    // the other child
    logic              r_qgo, n_qgo;
    t_free             r_free, n_free;
    t_free             r_miss, n_miss;
    logic              r_root_init, n_root_init;  // root not yet written since reset
    logic              r_bad, n_bad;              // erase path incomplete
    logic              r_fresh, n_fresh;          // current node allocated on this walk
    xtm_pkg::t_status  r_st, n_st;
    xtm_pkg::t_entry   w_node;
    xtm_pkg::t_mem_req w_req;
    logic              w_bit;
    xtm_pkg::t_node    w_child;
    logic              w_last;
    logic              w_zero;
    logic              w_refuse;

    // Null node, fresh nodes and the root before its first write read as zero.
    assign w_zero   = (r_u == '0) || r_fresh || (r_u == ROOT && r_root_init);
    assign w_node   = w_zero ? '0 : i_rd_data;
    assign w_bit    = r_key[r_lvl];
    assign w_child  = w_bit ? w_node.link1 : w_node.link0;
    assign w_last   = (r_lvl == '0);
    // At the decision step: store too small for the insert, or erase key absent.
    assign w_refuse = (r_act == xtm_pkg::ACT_INSERT)
                    ? ({1'b0, r_free} + {1'b0, r_miss} > {1'b0, FREE_LIM})
                    : (r_bad || w_node.cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= xtm_pkg::S_IDLE;
            r_free      <= FREE_RST;
            r_root_init <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_free      <= n_free;
            r_root_init <= n_root_init;
        end
        if (i_start) begin
            r_act <= i_act;
            r_key <= i_key;
        end
        r_lvl   <= n_lvl;
        r_u     <= n_u;
        r_qc    <= n_qc;
        r_qalt  <= n_qalt;
        r_qgo   <= n_qgo;
        r_y     <= n_y;
        r_miss  <= n_miss;
        r_bad   <= n_bad;
        r_fresh <= n_fresh;
        r_st    <= n_st;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            xtm_pkg::S_IDLE:   if (i_start) n_state = xtm_pkg::S_RROOT;
            xtm_pkg::S_RROOT:  n_state = xtm_pkg::S_WROOT;
            xtm_pkg::S_WROOT: begin
                if (r_act == xtm_pkg::ACT_INSERT || r_act == xtm_pkg::ACT_ERASE) begin
                    n_state = xtm_pkg::S_PASS1;
                end else if (w_node.cnt == '0) begin
                    n_state = xtm_pkg::S_DONE;
                end else begin
                    n_state = xtm_pkg::S_QUERY;
                end
            end
            xtm_pkg::S_PASS1:  n_state = xtm_pkg::S_P1WAIT;
            xtm_pkg::S_P1WAIT: n_state =
                (w_last || (r_act == xtm_pkg::ACT_ERASE && w_child == '0)) ?
                xtm_pkg::S_DECIDE : xtm_pkg::S_PASS1;
            xtm_pkg::S_DECIDE: n_state = w_refuse ? xtm_pkg::S_DONE : xtm_pkg::S_PASS2;
            xtm_pkg::S_PASS2:  n_state = xtm_pkg::S_P2WAIT;
            xtm_pkg::S_P2WAIT: n_state = r_bad ? xtm_pkg::S_DONE : xtm_pkg::S_PASS2;
            xtm_pkg::S_QUERY:  n_state = xtm_pkg::S_QWAIT;
            xtm_pkg::S_QWAIT:  n_state = xtm_pkg::S_QCHILD;
            xtm_pkg::S_QCHILD: n_state = xtm_pkg::S_QCWAIT;
            xtm_pkg::S_QCWAIT: n_state = w_last ? xtm_pkg::S_DONE : xtm_pkg::S_QUERY;
            // Hold the result until the output register can take it.
            xtm_pkg::S_DONE:   n_state = i_free ? xtm_pkg::S_IDLE : xtm_pkg::S_DONE;
            default:           n_state = xtm_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory requests.
    always_comb begin
        logic            pref;
        xtm_pkg::t_node  c;
        xtm_pkg::t_entry e;
        logic            go;
        pref = 1'b0;
        c = '0;
        e = '0;
        go = 1'b0;
        n_lvl = r_lvl;
        n_u = r_u;
        n_qc = r_qc;
        n_qalt = r_qalt;
        n_qgo = r_qgo;
        n_y = r_y;
        n_miss = r_miss;
        n_bad = r_bad;
        n_fresh = r_fresh;
        n_st = r_st;
        n_free = r_free;
        n_root_init = r_root_init;
        w_req = '0;
        case (r_state)
            xtm_pkg::S_IDLE: begin
                n_lvl = TOP_LVL;
                n_u = ROOT;
                n_y = '0;
                n_miss = '0;
                n_bad = 1'b0;
                n_fresh = 1'b0;
                n_st = xtm_pkg::ST_OK;
            end
            xtm_pkg::S_RROOT: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = r_u;
            end
            xtm_pkg::S_WROOT: begin
                if (r_act == xtm_pkg::ACT_MIN && w_node.cnt == '0) begin
                    n_st = xtm_pkg::ST_EMPTY;
                end
            end
            xtm_pkg::S_PASS1: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = r_u;
            end
            xtm_pkg::S_P1WAIT: begin
                // A null node has no children, so its path stays null.
                if (w_child == '0) begin
                    n_miss = r_miss + 1'b1;
                    n_bad = 1'b1;
                end
                n_u = w_child;
                n_lvl = r_lvl - 1'b1;
                if (w_last && r_act == xtm_pkg::ACT_ERASE && w_child != '0) begin
                    // Fetch the leaf; its count decides at the next step.
                    w_req.rd_en = 1'b1;
                    w_req.rd_addr = w_child;
                end
            end
            xtm_pkg::S_DECIDE: begin
                if (w_refuse) begin
                    n_st = (r_act == xtm_pkg::ACT_INSERT) ? xtm_pkg::ST_FULL
                                                          : xtm_pkg::ST_ABSENT;
                end
                n_lvl = TOP_LVL;
                n_u = ROOT;
                n_bad = 1'b0;   // now marks the leaf step in pass 2
                n_fresh = 1'b0;
            end
            xtm_pkg::S_PASS2: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = r_u;
            end
            xtm_pkg::S_P2WAIT: begin
                // Update the current node: count, and link on insert.
                e = w_node;
                c = w_child;
                if (r_u == ROOT) n_root_init = 1'b0;
                if (r_act == xtm_pkg::ACT_INSERT) begin
                    if (e.cnt != xtm_pkg::COUNT_MAX) e.cnt = e.cnt + 1'b1;
                    if (!r_bad && c == '0) begin
                        // Allocate; the fresh node reads as zero from here on.
                        c = r_free[xtm_pkg::NODE_BITS-1:0];
                        n_free = r_free + 1'b1;
                        n_fresh = 1'b1;
                        if (w_bit) e.link1 = c; else e.link0 = c;
                    end
                end else begin
                    if (e.cnt != '0) e.cnt = e.cnt - 1'b1;
                end
                w_req.wr_en = 1'b1;
                w_req.wr_addr = r_u;
                w_req.wr_data = e;
                n_u = r_bad ? '0 : c;
                n_bad = w_last;
                n_lvl = w_last ? r_lvl : r_lvl - 1'b1;
            end
            xtm_pkg::S_QUERY: begin
                w_req.rd_en = 1'b1;
                w_req.rd_addr = r_u;
            end
            xtm_pkg::S_QWAIT: begin
                pref = w_bit ^ (r_act == xtm_pkg::ACT_MAX);
                n_qgo = pref;
                n_qc = pref ? w_node.link1 : w_node.link0;
                n_qalt = pref ? w_node.link0 : w_node.link1;
                w_req.rd_en = 1'b1;
                w_req.rd_addr = n_qc;
            end
            xtm_pkg::S_QCHILD: begin
                // Child entry arrives now and holds in the read register.
            end
            xtm_pkg::S_QCWAIT: begin
                go = r_qgo;
                c = r_qc;
                if (r_qc == '0 || i_rd_data.cnt == '0) begin
                    // Dead end: take the other child anyway.
                    go = ~r_qgo;
                    c = r_qalt;
                end
                n_y = r_y | (xtm_pkg::t_key'(go) << r_lvl);
                n_u = c;
                n_lvl = w_last ? r_lvl : r_lvl - 1'b1;
            end
            default: ;
        endcase
    end

    assign o_req     = w_req;
    assign o_done    = (r_state == xtm_pkg::S_DONE);
    assign o_status  = r_st;
    assign o_xor     = (r_act == xtm_pkg::ACT_INSERT || r_act == xtm_pkg::ACT_ERASE ||
                        r_st == xtm_pkg::ST_EMPTY) ? '0 : r_key ^ r_y;
    assign o_partner = (r_act == xtm_pkg::ACT_INSERT || r_act == xtm_pkg::ACT_ERASE) ?
                       '0 : r_y;
endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench for the xor trie multiset unit: directed and random items checked against a trie predictor.
`timescale 1ns / 100ps
module tb;
    // Expected content of one result item.
    typedef struct {
        xtm_pkg::t_status status;
        xtm_pkg::t_key    xor_value;
        xtm_pkg::t_key    partner;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = 2'd0;
    logic [30:0] i_key = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [30:0] o_xor_value;
    logic [30:0] o_partner;

    xor_trie_multiset_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_xor_value(o_xor_value),
        .o_partner  (o_partner)
    );

    always #5 i_clk = ~i_clk;

    // Shadow trie: links, pass counts and the allocation pointer.
    xtm_pkg::t_node trie_zero [xtm_pkg::NODE_COUNT];
    xtm_pkg::t_node trie_one  [xtm_pkg::NODE_COUNT];
    xtm_pkg::t_cnt  trie_cnt  [xtm_pkg::NODE_COUNT];
    int             free_node;
    xtm_pkg::t_key  held_keys [$];   // keys currently in the multiset, with repeats
    t_answer        pending   [$];   // answers still owed by the block
    int             errors = 0;
    bit             calm = 1'b0;     // no idling on either side when set

    function automatic int trie_link(int u, bit b);
        if (u == 0) return 0;
        return b ? int'(trie_one[u]) : int'(trie_zero[u]);
    endfunction

    function automatic int trie_count(int u);
        return (u == 0) ? 0 : int'(trie_cnt[u]);
    endfunction

    function automatic xtm_pkg::t_status trie_insert(xtm_pkg::t_key k);
        int u;
        int c;
        int missing;
        u = 1;
        missing = 0;
        for (int lvl = xtm_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            c = trie_link(u, k[lvl]);
            if (c == 0) missing++;
            u = c;
        end
        if (free_node + missing > xtm_pkg::NODE_COUNT) return xtm_pkg::ST_FULL;
        u = 1;
        if (trie_cnt[1] != xtm_pkg::COUNT_MAX) trie_cnt[1]++;
        for (int lvl = xtm_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            c = trie_link(u, k[lvl]);
            if (c == 0) begin
                c = free_node++;
                trie_zero[c] = '0;
                trie_one[c] = '0;
                trie_cnt[c] = '0;
                if (k[lvl]) trie_one[u] = xtm_pkg::t_node'(c);
                else trie_zero[u] = xtm_pkg::t_node'(c);
            end
            u = c;
            if (trie_cnt[u] != xtm_pkg::COUNT_MAX) trie_cnt[u]++;
        end
        held_keys = {held_keys, k};
        return xtm_pkg::ST_OK;
    endfunction

    function automatic xtm_pkg::t_status trie_erase(xtm_pkg::t_key k);
        int u;
        u = 1;
        for (int lvl = xtm_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            u = trie_link(u, k[lvl]);
            if (u == 0) return xtm_pkg::ST_ABSENT;
        end
        if (trie_count(u) == 0) return xtm_pkg::ST_ABSENT;
        u = 1;
        if (trie_cnt[1] != 0) trie_cnt[1]--;
        for (int lvl = xtm_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            u = trie_link(u, k[lvl]);
            if (u != 0 && trie_cnt[u] != 0) trie_cnt[u]--;
        end
        foreach (held_keys[i]) begin
            if (held_keys[i] == k) begin
                held_keys.delete(i);
                break;
            end
        end
        return xtm_pkg::ST_OK;
    endfunction

    // Walk from the top bit; prefer the child that differs (max) or matches (min).
    function automatic xtm_pkg::t_key trie_walk(xtm_pkg::t_key k, bit differ);
        int u;
        int c;
        bit go;
        xtm_pkg::t_key found;
        u = 1;
        found = '0;
        for (int lvl = xtm_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
            go = k[lvl] ^ differ;
            c = trie_link(u, go);
            if (c == 0 || trie_count(c) == 0) begin
                go = ~go;
                c = trie_link(u, go);
            end
            found[lvl] = go;
            u = c;
        end
        return found;
    endfunction

    function automatic t_answer trie_apply(xtm_pkg::t_act a, xtm_pkg::t_key k);
        t_answer r;
        r.status = xtm_pkg::ST_OK;
        r.xor_value = '0;
        r.partner = '0;
        case (a)
            xtm_pkg::ACT_INSERT: r.status = trie_insert(k);
            xtm_pkg::ACT_ERASE:  r.status = trie_erase(k);
            default: begin
                if (trie_cnt[1] == 0) begin
                    if (a == xtm_pkg::ACT_MAX) r.xor_value = k;
                    else r.status = xtm_pkg::ST_EMPTY;
                end else begin
                    r.partner = trie_walk(k, a == xtm_pkg::ACT_MAX);
                    r.xor_value = k ^ r.partner;
                end
            end
        endcase
        return r;
    endfunction

    // Present one item, hold it until taken, then maybe leave a gap.
    task automatic send_item(xtm_pkg::t_act a, xtm_pkg::t_key k);
        t_answer r;
        r = trie_apply(a, k);
        pending = {pending, r};
        i_valid <= 1'b1;
        i_action <= a;
        i_key <= k;
        do @(posedge i_clk); while (!o_ready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until every owed answer has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
    endtask

    // Receiver side: random stall bursts, none in the calm phase.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (calm) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compare each result item with the oldest owed answer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending.size() == 0) begin
                $error("result item with no expectation: status %0d", o_status);
                errors++;
            end else begin
                t_answer e;
                e = pending.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d actual %0d", e.status, o_status);
                    errors++;
                end
                if (o_xor_value !== e.xor_value) begin
                    $error("xor_value: expected %h actual %h", e.xor_value, o_xor_value);
                    errors++;
                end
                if (o_partner !== e.partner) begin
                    $error("partner: expected %h actual %h", e.partner, o_partner);
                    errors++;
                end
            end
        end
    end

    function automatic xtm_pkg::t_key pick_key();
        case ($urandom_range(0, 4))
            0: return xtm_pkg::t_key'($urandom_range(0, 63));
            1: if (held_keys.size() != 0)
                   return held_keys[$urandom_range(0, held_keys.size() - 1)];
            2: if (held_keys.size() != 0)
                   return held_keys[$urandom_range(0, held_keys.size() - 1)]
                          ^ (xtm_pkg::t_key'(1) << $urandom_range(0, xtm_pkg::KEY_BITS - 1));
            default: ;
        endcase
        return xtm_pkg::t_key'($urandom);
    endfunction

    // Random mix; keys are small, held, held with one bit flipped, or random.
    task automatic random_mix(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) send_item(xtm_pkg::ACT_INSERT, pick_key());
            else if (r < 65) send_item(xtm_pkg::ACT_ERASE, pick_key());
            else if (r < 82) send_item(xtm_pkg::ACT_MAX, pick_key());
            else send_item(xtm_pkg::ACT_MIN, pick_key());
        end
    endtask

    // Empty set, both key extremes, duplicates, absent erase, erase back to empty.
    task automatic test_directed();
        send_item(xtm_pkg::ACT_MAX, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_MIN, 31'h1234_5678);
        send_item(xtm_pkg::ACT_ERASE, 31'h0);
        send_item(xtm_pkg::ACT_INSERT, 31'h0);
        send_item(xtm_pkg::ACT_MAX, 31'h0);
        send_item(xtm_pkg::ACT_MIN, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_INSERT, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_INSERT, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_MAX, 31'h0);
        send_item(xtm_pkg::ACT_MIN, 31'h4000_0000);
        send_item(xtm_pkg::ACT_ERASE, 31'h7FFF_FFFE);
        send_item(xtm_pkg::ACT_ERASE, 31'h5555_5555);
        send_item(xtm_pkg::ACT_ERASE, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_MIN, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_ERASE, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_ERASE, 31'h7FFF_FFFF);
        send_item(xtm_pkg::ACT_MAX, 31'h2AAA_AAAA);
        send_item(xtm_pkg::ACT_ERASE, 31'h0);
        send_item(xtm_pkg::ACT_MAX, 31'h1555_5555);
        send_item(xtm_pkg::ACT_MIN, 31'h0);
        send_item(xtm_pkg::ACT_INSERT, 31'h2AAA_AAAA);
        send_item(xtm_pkg::ACT_MAX, 31'h2AAA_AAAA);
        send_item(xtm_pkg::ACT_MIN, 31'h2AAA_AAAA);
        drain();
    endtask

    // Pause once mid-run until every answer has returned.
    task automatic test_random();
        random_mix(600);
        drain();
        random_mix(550);
        drain();
    endtask

    task automatic test_no_idle();
        calm = 1'b1;
        random_mix(280);
        drain();
    endtask

    initial begin
        trie_zero[1] = '0;
        trie_one[1] = '0;
        trie_cnt[1] = '0;
        free_node = 2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        test_no_idle();
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #40ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
